// ===== rtl/core/yuv_to_rgb_change_skip_defines.svh =====
// Assertion macros for the YUV to RGB change-skip converter
`ifndef YUV_TO_RGB_CHANGE_SKIP_DEFINES_SVH
`define YUV_TO_RGB_CHANGE_SKIP_DEFINES_SVH

// Same-cycle check, disabled while reset is held
`define YRCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check, disabled while reset is held
`define YRCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/yrcs_pkg.sv =====
// Shared types and widths for the YUV to RGB change-skip converter
`default_nettype none

package yrcs_pkg;

    localparam int unsigned PixW = 8;

    // One converted pixel as it moves between the color and gray sections
    typedef struct packed {
        logic            write_pixel;
        logic [PixW-1:0] red;
        logic [PixW-1:0] green;
        logic [PixW-1:0] blue;
    } t_pix;

endpackage

`default_nettype wire

// ===== rtl/core/yuv_to_rgb_change_skip.sv =====
// Top level: YCbCr to RGB converter with previous-frame change skip
//
// Input word (s_axis): one pixel's luma and shared chroma plus the same three
//   samples from the previous frame. Output word (m_axis): RGB, or the gray
//   level on all three channels when gray mode is set; m_axis_tuser is the
//   write flag, low when all three samples match the previous frame, and
//   then the channels are zero.
// Config: i_cfg_wr_en writes bit 0 of i_cfg_wr_data into gray mode. Change it
//   only while no word is in flight.
// Pipeline: four register stages (products, sum/clamp, luma weights,
//   gray select). Throughput is one word per clock while m_axis_tready
//   is high; each stage advances whenever its successor is empty or moving,
//   so bubbles collapse.
// Stall: with m_axis_tready low the output word holds; the pipe keeps filling
//   until all four stages are occupied, then s_axis_tready drops. Nothing is
//   dropped or repeated.
// Reset: i_rst_n (synchronous, active low) empties every stage and clears
//   gray mode to color output.
`default_nettype none

`include "yuv_to_rgb_change_skip_defines.svh"

module yuv_to_rgb_change_skip (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic        i_cfg_wr_data,   // gray_mode
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // luma[7:0], chroma_b[15:8], chroma_r[23:16],
    // prev_luma[31:24], prev_chroma_b[39:32], prev_chroma_r[47:40]
    input  wire logic [47:0] s_axis_tdata,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [23:0] m_axis_tdata,    // red[7:0], green[15:8], blue[23:16]
    output      logic        m_axis_tuser     // write_pixel
);

    logic           r_gray_mode;
    logic           w_mid_valid;
    logic           w_mid_ready;
    yrcs_pkg::t_pix w_mid_pix;
    yrcs_pkg::t_pix w_out_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_gray_mode <= i_cfg_wr_data;
        end
    end

    // stages 1-2: change test, chroma products, RGB sums and clamp
    yrcs_conv u_conv (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_luma          (s_axis_tdata[7:0]),
        .i_chroma_b      (s_axis_tdata[15:8]),
        .i_chroma_r      (s_axis_tdata[23:16]),
        .i_prev_luma     (s_axis_tdata[31:24]),
        .i_prev_chroma_b (s_axis_tdata[39:32]),
        .i_prev_chroma_r (s_axis_tdata[47:40]),
        .o_valid         (w_mid_valid),
        .i_ready         (w_mid_ready),
        .o_pix           (w_mid_pix)
    );

    // stages 3-4: luminance weights and output select; stage 4 is the output register
    yrcs_gray u_gray (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gray_mode (r_gray_mode),
        .i_valid     (w_mid_valid),
        .o_ready     (w_mid_ready),
        .i_pix       (w_mid_pix),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_pix       (w_out_pix)
    );

    assign m_axis_tdata = {w_out_pix.blue, w_out_pix.green, w_out_pix.red};
    assign m_axis_tuser = w_out_pix.write_pixel;

    // skipped pixels carry zero color
    `YRCS_ASSERT_NOW(a_skip_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 24'd0, "skipped word has nonzero color")

    // gray mode puts one level on all channels
    `YRCS_ASSERT_NOW(a_gray_equal, i_clk, i_rst_n, m_axis_tvalid && r_gray_mode, (m_axis_tdata[7:0] == m_axis_tdata[15:8]) && (m_axis_tdata[15:8] == m_axis_tdata[23:16]), "gray word channels differ")

    // an empty output stage lets the whole pipe move
    `YRCS_ASSERT_NOW(a_ready_when_drained, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty output stage")

    // a stalled output word holds until it is taken
    `YRCS_ASSERT_NEXT(a_hold_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed under stall")

endmodule

`default_nettype wire

// ===== rtl/core/yrcs_conv.sv =====
// Change detection and YCbCr to RGB color math, two pipeline stages
`default_nettype none

module yrcs_conv (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output      logic                       o_ready,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_luma,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_chroma_b,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_chroma_r,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_prev_luma,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_prev_chroma_b,
    input  wire logic [yrcs_pkg::PixW-1:0]  i_prev_chroma_r,
    output      logic                       o_valid,
    input  wire logic                       i_ready,
    output      yrcs_pkg::t_pix             o_pix
);

    localparam logic signed [17:0] CoefRv = 18'sd358;
    localparam logic signed [17:0] CoefGu = 18'sd88;
    localparam logic signed [17:0] CoefGv = 18'sd182;
    localparam logic signed [17:0] CoefBu = 18'sd453;

    // floor(x / 256) clamped to 0..255
    function automatic logic [7:0] shift_clamp(input logic signed [18:0] x);
        logic [7:0] q;
        if (x[18]) begin
            q = 8'd0;
        end else if (|x[17:16]) begin
            q = 8'hFF;
        end else begin
            q = x[15:8];
        end
        return q;
    endfunction

    logic              w_ready1;
    logic              w_ready2;
    logic              w_same;
    logic signed [7:0] w_u;
    logic signed [7:0] w_v;

    // stage 1: products
    logic                    r1_valid;
    logic                    r1_write;
    logic [7:0]              r1_y;
    logic signed [17:0]      r1_prv;
    logic signed [17:0]      r1_pgu;
    logic signed [17:0]      r1_pgv;
    logic signed [17:0]      r1_pbu;

    // stage 2: sums and clamp
    logic signed [18:0]      w_ys;
    logic signed [18:0]      w_sum_r;
    logic signed [18:0]      w_sum_g;
    logic signed [18:0]      w_sum_b;
    logic                    r2_valid;
    yrcs_pkg::t_pix          r2_pix;

    assign w_ready2 = !r2_valid || i_ready;
    assign w_ready1 = !r1_valid || w_ready2;
    assign o_ready  = w_ready1;

    assign w_same = (i_luma == i_prev_luma) && (i_chroma_b == i_prev_chroma_b)
                 && (i_chroma_r == i_prev_chroma_r);

    // sample - 128 is the sample with its top bit flipped, read as signed
    assign w_u = signed'(i_chroma_b ^ 8'h80);
    assign w_v = signed'(i_chroma_r ^ 8'h80);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r1_write <= !w_same;
            r1_y     <= i_luma;
            r1_prv   <= 18'(w_v) * CoefRv;
            r1_pgu   <= 18'(w_u) * CoefGu;
            r1_pgv   <= 18'(w_v) * CoefGv;
            r1_pbu   <= 18'(w_u) * CoefBu;
        end
    end

    assign w_ys    = signed'({3'b000, r1_y, 8'h00});
    assign w_sum_r = w_ys + 19'(r1_prv);
    assign w_sum_g = w_ys - 19'(r1_pgu) - 19'(r1_pgv);
    assign w_sum_b = w_ys + 19'(r1_pbu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_ready2) begin
            r2_valid <= r1_valid;
        end
    end

    // unchanged pixels leave this stage as all-zero color
    always_ff @(posedge i_clk) begin
        if (w_ready2 && r1_valid) begin
            r2_pix.write_pixel <= r1_write;
            r2_pix.red         <= r1_write ? shift_clamp(w_sum_r) : 8'd0;
            r2_pix.green       <= r1_write ? shift_clamp(w_sum_g) : 8'd0;
            r2_pix.blue        <= r1_write ? shift_clamp(w_sum_b) : 8'd0;
        end
    end

    assign o_valid = r2_valid;
    assign o_pix   = r2_pix;

endmodule

`default_nettype wire

// ===== rtl/core/yrcs_gray.sv =====
// Luminance weighting and gray/color select, two pipeline stages with output register
`default_nettype none

module yrcs_gray (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_gray_mode,
    input  wire logic            i_valid,
    output      logic            o_ready,
    input  wire yrcs_pkg::t_pix  i_pix,
    output      logic            o_valid,
    input  wire logic            i_ready,
    output      yrcs_pkg::t_pix  o_pix
);

    // Q16 weights of 0.299, 0.587, 0.114
    localparam logic [23:0] GrayKr = 24'd19595;
    localparam logic [23:0] GrayKg = 24'd38470;
    localparam logic [23:0] GrayKb = 24'd7471;

    logic           w_ready3;
    logic           w_ready4;

    // stage 3: weighted products
    logic           r3_valid;
    yrcs_pkg::t_pix r3_pix;
    logic [23:0]    r3_pr;
    logic [23:0]    r3_pg;
    logic [23:0]    r3_pb;

    // stage 4: sum, scale, select
    logic [24:0]    w_sum;
    logic [7:0]     w_gray;
    logic           r4_valid;
    yrcs_pkg::t_pix r4_pix;

    assign w_ready4 = !r4_valid || i_ready;
    assign w_ready3 = !r3_valid || w_ready4;
    assign o_ready  = w_ready3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_ready3) begin
            r3_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready3 && i_valid) begin
            r3_pix <= i_pix;
            r3_pr  <= 24'(i_pix.red) * GrayKr;
            r3_pg  <= 24'(i_pix.green) * GrayKg;
            r3_pb  <= 24'(i_pix.blue) * GrayKb;
        end
    end

    assign w_sum  = 25'(r3_pr) + 25'(r3_pg) + 25'(r3_pb);
    assign w_gray = w_sum[24] ? 8'hFF : w_sum[23:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_ready4) begin
            r4_valid <= r3_valid;
        end
    end

    // skipped pixels are zero already, so gray of them is zero too
    always_ff @(posedge i_clk) begin
        if (w_ready4 && r3_valid) begin
            r4_pix.write_pixel <= r3_pix.write_pixel;
            r4_pix.red         <= i_gray_mode ? w_gray : r3_pix.red;
            r4_pix.green       <= i_gray_mode ? w_gray : r3_pix.green;
            r4_pix.blue        <= i_gray_mode ? w_gray : r3_pix.blue;
        end
    end

    assign o_valid = r4_valid;
    assign o_pix   = r4_pix;

endmodule

`default_nettype wire

// ===== bench/yuv_to_rgb_change_skip_tb.sv =====
// Self-checking bench for the YCbCr to RGB change-skip converter
`default_nettype none

module yuv_to_rgb_change_skip_tb;

    // Gray mode register values
    localparam bit MODE_COLOR = 1'b0;
    localparam bit MODE_GRAY  = 1'b1;

    // BT.601 integer coefficients, chroma offset, Q16 luminance weights
    localparam int CHROMA_MID = 128;
    localparam int COEF_RV    = 358;
    localparam int COEF_GU    = 88;
    localparam int COEF_GV    = 182;
    localparam int COEF_BU    = 453;
    localparam int CH_TOP     = 255;
    localparam longint unsigned GRAY_KR = 19595;
    localparam longint unsigned GRAY_KG = 38470;
    localparam longint unsigned GRAY_KB = 7471;

    // Quiet wait after the pipe drains, before register writes and the verdict
    localparam int PIPE_SETTLE    = 6;
    localparam int RAND_PER_PHASE = 205;
    localparam int TAIL_WORDS     = 150;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 2000;

    // Input word layout, luma in the low byte
    typedef struct packed {
        logic [7:0] prev_chroma_r;
        logic [7:0] prev_chroma_b;
        logic [7:0] prev_luma;
        logic [7:0] chroma_r;
        logic [7:0] chroma_b;
        logic [7:0] luma;
    } t_yuv_word;

    typedef struct {
        bit             mode;
        t_yuv_word      word;
        bit             known;   // expected result typed in, not predicted
        yrcs_pkg::t_pix want;
    } t_dir_row;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic        i_cfg_wr_data = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // luma, chroma_b, chroma_r, prev_luma, prev_cb, prev_cr
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // red, green, blue
    logic        m_axis_tuser;         // write_pixel

    yrcs_pkg::t_pix rgb_expect_q[$];
    t_dir_row       dir_rows[$];
    bit             gray_now     = MODE_COLOR;
    int             mismatch_cnt = 0;

    // Shared between the sender and the receiver; written with NBAs at the edge
    bit idle_en  = 1'b1;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    yuv_to_rgb_change_skip uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------

    // Floor shift by 8 (arithmetic on a signed int), then clamp to a byte
    function automatic logic [7:0] clamp_channel(input int acc);
        int q;
        q = acc >>> 8;
        if (q < 0) return 8'd0;
        if (q > CH_TOP) return 8'(CH_TOP);
        return q[7:0];
    endfunction

    function automatic yrcs_pkg::t_pix convert_pixel(input t_yuv_word w, input bit gray);
        yrcs_pkg::t_pix  px;
        int              ys;
        int              u;
        int              v;
        longint unsigned lum;
        px = '0;
        // unchanged against the previous frame: skip, channels stay zero
        if (w.luma == w.prev_luma && w.chroma_b == w.prev_chroma_b &&
            w.chroma_r == w.prev_chroma_r)
            return px;
        ys = int'(w.luma) * 256;
        u  = int'(w.chroma_b) - CHROMA_MID;
        v  = int'(w.chroma_r) - CHROMA_MID;
        px.write_pixel = 1'b1;
        px.red   = clamp_channel(ys + COEF_RV * v);
        px.green = clamp_channel(ys - COEF_GU * u - COEF_GV * v);
        px.blue  = clamp_channel(ys + COEF_BU * u);
        if (gray) begin
            // truncating Q16 luminance of the clamped channels
            lum = (GRAY_KR * px.red + GRAY_KG * px.green + GRAY_KB * px.blue) >> 16;
            if (lum > CH_TOP) lum = CH_TOP;
            px.red   = lum[7:0];
            px.green = lum[7:0];
            px.blue  = lum[7:0];
        end
        return px;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    task automatic add_row(input bit mode, input logic [7:0] y, cb, cr, py, pb, pr,
                           input bit known, input logic wp, input logic [7:0] r, g, b);
        t_dir_row row;
        row.mode  = mode;
        row.word  = {pr, pb, py, cr, cb, y};
        row.known = known;
        row.want  = '{write_pixel: wp, red: r, green: g, blue: b};
        dir_rows.push_back(row);
    endtask

    function automatic logic [7:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd127;
            3: return 8'd128;
            4: return 8'd254;
            default: return 8'd255;
        endcase
    endfunction

    // Mix: unchanged pixels, one sample nudged by one bit, extremes, fully random
    function automatic t_yuv_word random_word();
        t_yuv_word   w;
        logic [63:0] raw;
        int unsigned sel;
        raw = {$urandom, $urandom};
        w   = raw[47:0];
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            w.prev_luma     = w.luma;
            w.prev_chroma_b = w.chroma_b;
            w.prev_chroma_r = w.chroma_r;
            if (sel >= 25) begin
                case ($urandom_range(0, 2))
                    0: w.prev_luma     ^= 8'(1 << $urandom_range(0, 7));
                    1: w.prev_chroma_b ^= 8'(1 << $urandom_range(0, 7));
                    default: w.prev_chroma_r ^= 8'(1 << $urandom_range(0, 7));
                endcase
            end
        end else if (sel < 60) begin
            w.luma     = pick_extreme();
            w.chroma_b = pick_extreme();
            w.chroma_r = pick_extreme();
        end
        return w;
    endfunction

    // Offer one word and hold it until the block takes it
    task automatic send_word(input t_yuv_word w, input yrcs_pkg::t_pix want);
        s_axis_tdata  <= w;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        rgb_expect_q.push_back(want);
    endtask

    // Random sender gap; here valid drops only when a gap is taken
    task automatic idle_gap();
        if (idle_en && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // Wait until the pipe is empty, then write gray mode
    task automatic set_gray_mode(input bit mode);
        s_axis_tvalid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        gray_now     = mode;
    endtask

    //------------------------------------------------------------------
    // Sender: reset, directed table, random phases, quiet tail
    //------------------------------------------------------------------
    initial begin : stim
        t_yuv_word      w;
        yrcs_pkg::t_pix want;

        // mode  y    cb   cr   py   pb   pr  known wp  r    g    b
        add_row(MODE_COLOR,   0,   0,   0,   0,   0,   0, 1, 0,   0,   0,   0);
        add_row(MODE_COLOR, 255, 255, 255, 255, 255, 255, 1, 0,   0,   0,   0);
        add_row(MODE_COLOR,   0, 128, 128, 255, 128, 128, 1, 1,   0,   0,   0);
        add_row(MODE_COLOR, 255, 128, 128,   0, 128, 128, 1, 1, 255, 255, 255);
        add_row(MODE_COLOR,   0,   0,   0, 255, 255, 255, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR, 255, 255, 255,   0,   0,   0, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR,   0, 255,   0,   0, 255, 255, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR, 255,   0, 255, 255, 255, 255, 0, 0,   0,   0,   0);
        // only one of the three samples differs from the previous frame
        add_row(MODE_COLOR,  90,  60, 200,  91,  60, 200, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR,  90,  60, 200,  90,  61, 200, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR,  90,  60, 200,  90,  60, 201, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR, 128,   0, 255, 128,   0, 254, 0, 0,   0,   0,   0);
        add_row(MODE_GRAY,   77,  33, 199,  77,  33, 199, 1, 0,   0,   0,   0);
        add_row(MODE_GRAY,  255, 128, 128, 254, 128, 128, 1, 1, 255, 255, 255);
        add_row(MODE_GRAY,    0, 128, 128,   1, 128, 128, 1, 1,   0,   0,   0);
        add_row(MODE_GRAY,    0,   0,   0, 255,   0,   0, 0, 0,   0,   0,   0);
        add_row(MODE_GRAY,  255, 255, 255,   0, 255, 255, 0, 0,   0,   0,   0);
        add_row(MODE_GRAY,  200, 255,   0,   0,   0,   0, 0, 0,   0,   0,   0);
        add_row(MODE_GRAY,  100,  50, 200, 100,  50,  20, 0, 0,   0,   0,   0);
        add_row(MODE_COLOR,  76,  85, 255,   0,   0,   0, 0, 0,   0,   0,   0);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_gray_mode(MODE_COLOR);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].mode != gray_now)
                set_gray_mode(dir_rows[i].mode);
            want = dir_rows[i].known ? dir_rows[i].want
                                     : convert_pixel(dir_rows[i].word, gray_now);
            send_word(dir_rows[i].word, want);
            idle_gap();
        end

        // Random phases, alternating color and gray. Phase 1 also asks the
        // receiver for a long hold-off so the pipe fills and backs up.
        for (int ph = 0; ph < 6; ph++) begin
            set_gray_mode((ph % 2 == 1) ? MODE_GRAY : MODE_COLOR);
            idle_en <= (ph != 2 && ph != 5);
            if (ph == 1)
                hold_req <= 1'b1;
            repeat (RAND_PER_PHASE) begin
                w = random_word();
                send_word(w, convert_pixel(w, gray_now));
                idle_gap();
            end
        end

        // Tail: full rate on both sides
        set_gray_mode(MODE_COLOR);
        idle_en <= 1'b0;
        repeat (TAIL_WORDS) begin
            w = random_word();
            send_word(w, convert_pixel(w, gray_now));
        end

        s_axis_tvalid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (mismatch_cnt == 0 && rgb_expect_q.size() == 0)
            $display("** yuv_to_rgb_change_skip: PASSED **");
        else
            $display("** yuv_to_rgb_change_skip: FAILED **");
        $finish;
    end

    //------------------------------------------------------------------
    // Receiver: checks each output word, drives tready with stall bursts
    //------------------------------------------------------------------
    int  stall_left = 0;
    int  hold_left  = 0;
    bit  hold_taken = 1'b0;

    task automatic compare_field(input string name, input int unsigned want, got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_cnt++;
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        yrcs_pkg::t_pix want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (rgb_expect_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h/%b",
                         $time, m_axis_tdata, m_axis_tuser);
                mismatch_cnt++;
            end else begin
                want = rgb_expect_q.pop_front();
                compare_field("write_pixel", want.write_pixel, m_axis_tuser);
                compare_field("red",   want.red,   m_axis_tdata[7:0]);
                compare_field("green", want.green, m_axis_tdata[15:8]);
                compare_field("blue",  want.blue,  m_axis_tdata[23:16]);
            end
        end

        // long hold-off wins over everything else, once per run
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!idle_en) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    //------------------------------------------------------------------
    // Watchdog: cycles in a row with no word moving on either side
    //------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, quiet_cycles);
            $display("** yuv_to_rgb_change_skip: FAILED **");
            $finish;
        end
    end

endmodule

`default_nettype wire
